// File: rtl/bf16_dot_product_gemv_assert.svh
// Assertion macros used by the checker file.
`ifndef BF16_DOT_PRODUCT_GEMV_ASSERT_SVH
`define BF16_DOT_PRODUCT_GEMV_ASSERT_SVH

// same-cycle implication, ignored while in reset
`define BDG_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bf16 gemv: assertion failed");

// next-cycle implication, ignored while in reset
`define BDG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bf16 gemv: assertion failed");

// next-cycle implication, checked through reset as well
`define BDG_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("bf16 gemv: assertion failed");

`endif

// File: rtl/bf16dp_pkg.sv
package bf16dp_pkg;

    localparam int VEC_DEPTH = 4096;
    localparam int ADDR_W    = $clog2(VEC_DEPTH);
    localparam int LEN_W     = ADDR_W + 1;
    localparam int VEC_LEN_W = 13;
    localparam int COL_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_VEC_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_CNT = 2'd1;

    localparam logic [31:0] QNAN = 32'h7FC0_0000;

    // right shift keeping the lost bits as a sticky bit in bit 0
    function automatic logic [26:0] shr_sticky(input logic [26:0] m, input logic [9:0] sh);
        logic [26:0] mask;
        logic [26:0] r;
        mask = '0;
        if (sh >= 10'd27) begin
            r = {26'd0, |m};
        end else begin
            mask = ~(27'h7FF_FFFF << sh[4:0]);
            r = (m >> sh[4:0]) | {26'd0, |(m & mask)};
        end
        return r;
    endfunction

    // value = m * 2^(e-26), m has its leading one at bit 26 (or is zero)
    function automatic logic [31:0] round_pack(input logic s, input logic signed [11:0] e,
                                               input logic [26:0] m);
        logic signed [11:0] b;
        logic [26:0]        mm;
        logic [30:0]        mag;
        logic               rnd;
        logic [31:0]        res;
        b   = e + 12'sd127;
        mm  = m;
        mag = '0;
        if (m == 27'd0) begin
            res = {s, 31'd0};
        end else if (b >= 12'sd255) begin
            res = {s, 8'hFF, 23'd0};
        end else begin
            if (b >= 12'sd1) begin
                mag = {b[7:0], m[25:3]};
            end else begin
                mm  = shr_sticky(m, 10'(12'sd1 - b));
                mag = {8'd0, mm[25:3]};
            end
            rnd = mm[2] & ((|mm[1:0]) | mm[3]);
            // a carry out of the fraction bumps the exponent, up to infinity
            mag = mag + 31'(rnd);
            res = {s, mag};
        end
        return res;
    endfunction

    function automatic logic [31:0] bf16_mul(input logic [15:0] a, input logic [15:0] b);
        logic               s;
        logic               nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
        logic [7:0]         sa, sb;
        logic signed [11:0] xa, xb, e;
        logic [15:0]        p, pn;
        logic [4:0]         lz;
        logic [31:0]        res;
        s      = a[15] ^ b[15];
        nan_a  = (&a[14:7]) & (|a[6:0]);
        nan_b  = (&b[14:7]) & (|b[6:0]);
        inf_a  = (&a[14:7]) & ~(|a[6:0]);
        inf_b  = (&b[14:7]) & ~(|b[6:0]);
        zero_a = ~(|a[14:0]);
        zero_b = ~(|b[14:0]);
        sa     = {a[14:7] != 8'd0, a[6:0]};
        sb     = {b[14:7] != 8'd0, b[6:0]};
        xa     = $signed({4'd0, (a[14:7] == 8'd0) ? 8'd1 : a[14:7]}) - 12'sd134;
        xb     = $signed({4'd0, (b[14:7] == 8'd0) ? 8'd1 : b[14:7]}) - 12'sd134;
        p      = sa * sb;
        lz     = 5'd0;
        for (int i = 0; i < 16; i++) begin
            if (p[i]) lz = 5'(15 - i);
        end
        pn = p << lz;
        e  = xa + xb - $signed({7'd0, lz}) + 12'sd15;
        if (nan_a | nan_b | (inf_a & zero_b) | (inf_b & zero_a)) begin
            res = QNAN;
        end else if (inf_a | inf_b) begin
            res = {s, 8'hFF, 23'd0};
        end else begin
            res = round_pack(s, e, {pn, 11'd0});
        end
        return res;
    endfunction

    function automatic logic [31:0] fp32_add(input logic [31:0] x, input logic [31:0] y);
        logic               nan_x, nan_y, inf_x, inf_y, sub;
        logic [31:0]        big, sml, res;
        logic [7:0]         eb, es, d;
        logic [26:0]        mb, ms, m;
        logic [27:0]        r, rn;
        logic [4:0]         lz;
        logic signed [11:0] e;
        nan_x = (&x[30:23]) & (|x[22:0]);
        nan_y = (&y[30:23]) & (|y[22:0]);
        inf_x = (&x[30:23]) & ~(|x[22:0]);
        inf_y = (&y[30:23]) & ~(|y[22:0]);
        if (y[30:0] > x[30:0]) begin
            big = y;
            sml = x;
        end else begin
            big = x;
            sml = y;
        end
        eb  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        es  = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        d   = eb - es;
        mb  = {big[30:23] != 8'd0, big[22:0], 3'd0};
        ms  = shr_sticky({sml[30:23] != 8'd0, sml[22:0], 3'd0}, {2'd0, d});
        sub = big[31] ^ sml[31];
        r   = sub ? ({1'b0, mb} - {1'b0, ms}) : ({1'b0, mb} + {1'b0, ms});
        lz  = 5'd0;
        for (int i = 0; i < 28; i++) begin
            if (r[i]) lz = 5'(27 - i);
        end
        rn   = r << lz;
        m    = rn[27:1];
        m[0] = rn[1] | rn[0];
        e    = $signed({4'd0, eb}) - 12'sd126 - $signed({7'd0, lz});
        if (nan_x | nan_y | (inf_x & inf_y & (x[31] ^ y[31]))) begin
            res = QNAN;
        end else if (inf_x) begin
            res = x;
        end else if (inf_y) begin
            res = y;
        end else if (r == 28'd0) begin
            // exact cancellation gives +0; equal-signed zeros keep their sign
            res = {sub ? 1'b0 : big[31], 31'd0};
        end else begin
            res = round_pack(big[31], e, m);
        end
        return res;
    endfunction

endpackage

// File: rtl/bf16_dot_product_gemv.sv
// Channel   Direction  Handshake               Payload
// in        input      i_in_valid / o_in_stall  i_cmd, i_value
// out       output     o_out_valid / i_out_stall o_sum_bits, o_last_column
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One item per cycle while o_in_stall is low. A weight passes store read, bf16
// multiply and fp32 accumulate; the last weight of a column raises o_out_valid.
// Synchronous active-low reset clears counters and the accumulator; the
// activation store is not cleared. A held result stalls the pipeline and the
// input only once the next column sum waits behind it; a config write stalls
// the input for its own cycle.
module bf16_dot_product_gemv (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_cmd,
    input  logic [15:0]                       i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [31:0]                       o_sum_bits,
    output logic                              o_last_column,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bf16dp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bf16dp_pkg::CFG_DAT_W-1:0]  i_cfg_data
);
    import bf16dp_pkg::*;

    logic [15:0]          r_store [VEC_DEPTH];

    logic [VEC_LEN_W-1:0] r_vec_len;
    logic [COL_W-1:0]     r_col_cnt;
    logic [ADDR_W-1:0]    r_load_pos, n_load_pos;
    logic [ADDR_W-1:0]    r_mac_pos, n_mac_pos;
    logic [COL_W-1:0]     r_col_pos, n_col_pos;

    logic [LEN_W-1:0]     w_len;
    logic [COL_W-1:0]     w_cols;
    logic                 w_adv, w_acc_in, w_cfg_wr, w_cfg_hit, w_end, w_last;

    logic                 r_s1_valid, r_s1_end, r_s1_last;
    logic [15:0]          r_s1_weight, r_s1_act;
    logic                 r_s2_valid, r_s2_end, r_s2_last;
    logic [31:0]          r_s2_prod;
    logic [31:0]          r_acc, n_acc_sum;
    logic                 r_out_valid, r_out_last;
    logic [31:0]          r_out_sum;

    // only a finished column sum needs the output register
    assign w_adv     = ~(r_out_valid & i_out_stall & r_s2_valid & r_s2_end);
    assign w_cfg_wr  = i_cfg_valid;
    assign w_cfg_hit = (i_cfg_index == REG_VEC_LEN) || (i_cfg_index == REG_COL_CNT);
    assign w_acc_in  = i_in_valid & ~o_in_stall;

    assign o_in_stall    = ~w_adv | w_cfg_wr;
    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_sum_bits    = r_out_sum;
    assign o_last_column = r_out_last;

    always_comb begin
        if (r_vec_len == '0) begin
            w_len = LEN_W'(1);
        end else if (LEN_W'(r_vec_len) > LEN_W'(VEC_DEPTH)) begin
            w_len = LEN_W'(VEC_DEPTH);
        end else begin
            w_len = LEN_W'(r_vec_len);
        end
        w_cols = (r_col_cnt == '0) ? COL_W'(1) : r_col_cnt;
    end

    always_comb begin
        w_end      = (LEN_W'(r_mac_pos) + LEN_W'(1)) >= w_len;
        w_last     = ({1'b0, r_col_pos} + 17'd1) >= {1'b0, w_cols};
        n_load_pos = r_load_pos;
        n_mac_pos  = r_mac_pos;
        n_col_pos  = r_col_pos;
        if (w_acc_in) begin
            if (i_cmd == 1'b0) begin
                n_load_pos = ((LEN_W'(r_load_pos) + LEN_W'(1)) >= w_len) ? '0
                                                                          : r_load_pos + 1'b1;
            end else if (w_end) begin
                n_mac_pos = '0;
                n_col_pos = w_last ? '0 : r_col_pos + 1'b1;
            end else begin
                n_mac_pos = r_mac_pos + 1'b1;
            end
        end
        n_acc_sum = fp32_add(r_acc, r_s2_prod);
    end

    // store write on a load, registered read on a weight
    always_ff @(posedge i_clk) begin
        if (w_acc_in) begin
            if (i_cmd == 1'b0) begin
                r_store[r_load_pos] <= i_value;
            end else begin
                r_s1_act <= r_store[r_mac_pos];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vec_len   <= VEC_LEN_W'(1);
            r_col_cnt   <= COL_W'(1);
            r_load_pos  <= '0;
            r_mac_pos   <= '0;
            r_col_pos   <= '0;
            r_acc       <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                unique case (i_cfg_index)
                    REG_VEC_LEN: r_vec_len <= i_cfg_data[VEC_LEN_W-1:0];
                    REG_COL_CNT: r_col_cnt <= i_cfg_data[COL_W-1:0];
                    default: ;
                endcase
            end
            if (w_cfg_wr && w_cfg_hit) begin
                r_load_pos <= '0;
                r_mac_pos  <= '0;
                r_col_pos  <= '0;
                r_acc      <= '0;
            end else begin
                r_load_pos <= n_load_pos;
                r_mac_pos  <= n_mac_pos;
                r_col_pos  <= n_col_pos;
                if (w_adv && r_s2_valid) begin
                    r_acc <= r_s2_end ? '0 : n_acc_sum;
                end
            end
            if (w_adv) begin
                r_s1_valid <= w_acc_in & i_cmd;
                r_s2_valid <= r_s1_valid;
            end
            if (w_adv && r_s2_valid && r_s2_end) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_acc_in) begin
                r_s1_weight <= i_value;
                r_s1_end    <= w_end;
                r_s1_last   <= w_last;
            end
            r_s2_prod <= bf16_mul(r_s1_act, r_s1_weight);
            r_s2_end  <= r_s1_end;
            r_s2_last <= r_s1_last;
            if (r_s2_valid & r_s2_end) begin
                r_out_sum  <= n_acc_sum;
                r_out_last <= r_s2_last;
            end
        end
    end

endmodule

// File: rtl/bf16dp_checker.sv
`include "bf16_dot_product_gemv_assert.svh"

module bf16dp_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              i_cmd,
    input logic [15:0]                       i_value,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [31:0]                       o_sum_bits,
    input logic                              o_last_column,
    input logic                              i_cfg_valid,
    input logic                              o_cfg_ready,
    input logic [bf16dp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input logic [bf16dp_pkg::CFG_DAT_W-1:0]  i_cfg_data
);
    import bf16dp_pkg::*;

    logic w_held;
    assign w_held = o_out_valid & i_out_stall;

    `BDG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_held, o_out_valid)
    `BDG_ASSERT_NEXT(a_sum_stable, i_clk, i_rst_n, w_held, $stable({o_sum_bits, o_last_column}))
    `BDG_ASSERT_IMPLY(a_cfg_stall, i_clk, i_rst_n, i_cfg_valid, o_in_stall)
    `BDG_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_out_valid && (!o_in_stall || i_cfg_valid))

endmodule

bind bf16_dot_product_gemv bf16dp_checker u_bf16dp_checker (.*);
